// ===== design/adc_oversample_accumulator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ADC_OVERSAMPLE_ACCUMULATOR_DEFINES_SVH
`define ADC_OVERSAMPLE_ACCUMULATOR_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define ADC_OA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked at the edge after the antecedent.
`define ADC_OA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/adc_oa_pkg.sv =====
package adc_oa_pkg;

	localparam int unsigned CHANNELS    = 5;
	localparam int unsigned SAMPLE_BITS = 12;
	localparam int unsigned CH_W        = 3;
	localparam int unsigned CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned FACTOR_W    = 9;
	localparam int unsigned IN_USE_W    = 3;
	localparam int unsigned READING_W   = 16;
	localparam int unsigned CFG_DATA_W  = 9;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned ACC_W       = 32;

	localparam logic [CH_W:0]           CH_COUNT      = (CH_W + 1)'(CHANNELS);
	localparam logic [ACC_W-1:0]        RESCALE_LIMIT = 32'hFFFF_F000;
	localparam logic [ACC_W-1:0]        COUNT_MAX     = 32'hFFFF_FFFF;
	localparam logic [READING_W-1:0]    READING_MAX   = 16'hFFFF;
	localparam logic [FACTOR_W-1:0]     FACTOR_RESET  = 9'd16;
	localparam logic [IN_USE_W-1:0]     IN_USE_RESET  = 3'd5;

	// request type codes
	localparam logic [1:0] REQ_FRAME = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_USE = 1'b1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [1:0]      req_type;
		logic [CH_W-1:0] channel;
		logic [11:0]     sample_0;
		logic [11:0]     sample_1;
		logic [11:0]     sample_2;
		logic [11:0]     sample_3;
		logic [11:0]     sample_4;
	} req_item_t;

	typedef struct packed {
		logic [READING_W-1:0] reading;
		logic                 ready_res;
	} res_item_t;

	typedef enum logic [1:0] {
		OP_FRAME,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [CH_W-1:0]            channel;
		sample_t [CHANNELS-1:0]     samples;
	} qent_t;

	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [IN_USE_W-1:0] in_use;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [ACC_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [ACC_W-1:0] quotient;
		logic [ACC_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_CLEAR,
		BK_FRAME,
		BK_RESCALE,
		BK_RD_CHECK,
		BK_RD_DIV1,
		BK_RD_MUL,
		BK_RD_SUB,
		BK_RD_DIV2,
		BK_OUT
	} bk_state_t;

endpackage

// ===== design/adc_oa_div.sv =====
module adc_oa_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adc_oa_pkg::div_req_t req,
	output adc_oa_pkg::div_rsp_t rsp
);

	localparam int unsigned DIV_W  = adc_oa_pkg::ACC_W;
	localparam int unsigned STEP_W = $clog2(DIV_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dvs_q;

	logic [DIV_W:0]    shifted;
	logic [DIV_W:0]    diff;
	logic              fits;
	logic              launch;

	assign launch  = req.start && !busy_q;
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST_STEP);
			if (launch) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (launch) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== design/adc_oa_front.sv =====
module adc_oa_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  adc_oa_pkg::req_item_t req_item,
	input  logic                  pop,
	output logic                  q_valid,
	output adc_oa_pkg::qent_t     q_head
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W:0] FULL = (PTR_W + 1)'(DEPTH);

	adc_oa_pkg::qent_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    fill_q;

	adc_oa_pkg::qent_t entry;
	logic              keep;
	logic              push;
	logic              take;

	// classify: drop unused request types and clears of missing channels
	always_comb begin
		entry.channel    = req_item.channel;
		entry.samples[0] = req_item.sample_0;
		entry.samples[1] = req_item.sample_1;
		entry.samples[2] = req_item.sample_2;
		entry.samples[3] = req_item.sample_3;
		entry.samples[4] = req_item.sample_4;
		unique case (req_item.req_type)
			adc_oa_pkg::REQ_FRAME: begin
				entry.op = adc_oa_pkg::OP_FRAME;
				keep     = 1'b1;
			end
			adc_oa_pkg::REQ_READ: begin
				entry.op = adc_oa_pkg::OP_READ;
				keep     = 1'b1;
			end
			adc_oa_pkg::REQ_CLEAR: begin
				entry.op = adc_oa_pkg::OP_CLEAR;
				keep     = {1'b0, req_item.channel} < adc_oa_pkg::CH_COUNT;
			end
			default: begin
				entry.op = adc_oa_pkg::OP_FRAME;
				keep     = 1'b0;
			end
		endcase
	end

	assign req_stall = (fill_q == FULL);
	assign q_valid   = (fill_q != '0);
	assign q_head    = mem_q[rd_ptr_q];
	assign push      = req_valid && !req_stall && keep;
	assign take      = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

endmodule

// ===== design/adc_oa_back.sv =====
module adc_oa_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  adc_oa_pkg::cfg_t      cfg,
	input  logic                  q_valid,
	input  adc_oa_pkg::qent_t     q_head,
	output logic                  pop,
	output adc_oa_pkg::div_req_t  div_req,
	input  adc_oa_pkg::div_rsp_t  div_rsp,
	output logic                  res_valid,
	input  logic                  res_stall,
	output adc_oa_pkg::res_item_t res_item
);

	localparam int unsigned IW    = adc_oa_pkg::CH_IDX_W;
	localparam int unsigned AW    = adc_oa_pkg::ACC_W;
	localparam int unsigned SW    = adc_oa_pkg::SAMPLE_BITS;
	localparam int unsigned FW    = adc_oa_pkg::FACTOR_W;
	localparam int unsigned PW    = SW + FW;
	localparam int unsigned RW    = adc_oa_pkg::READING_W;
	localparam logic [IW-1:0] LAST_CH = IW'(adc_oa_pkg::CHANNELS - 1);

	adc_oa_pkg::bk_state_t state_q;
	adc_oa_pkg::bk_state_t state_d;

	adc_oa_pkg::qent_t     cur_q;
	logic [IW-1:0]         idx_q;
	logic [AW-1:0]         sum_q  [adc_oa_pkg::CHANNELS];
	logic [AW-1:0]         cnt_q  [adc_oa_pkg::CHANNELS];
	logic [SW-1:0]         last_q [adc_oa_pkg::CHANNELS];
	logic [AW-1:0]         q1_q;
	logic [FW-1:0]         rem_q;
	logic [PW-1:0]         prod_q;
	logic [RW-1:0]         val_q;
	logic                  rdy_q;
	logic                  res_valid_q;
	adc_oa_pkg::res_item_t res_q;

	logic [IW-1:0] acc_idx;
	logic [IW-1:0] cur_idx;
	logic [AW-1:0] sum_sel;
	logic [AW-1:0] cnt_sel;
	logic [SW-1:0] last_sel;
	logic [SW-1:0] smp;
	logic [AW-1:0] new_sum;
	logic [AW-1:0] new_cnt;
	logic          need_rescale;
	logic          last_idx;
	logic [FW-1:0] f_eff;
	logic          f_one;
	logic          ch_ok;
	logic          short_cnt;
	logic [AW-1:0] prod_ext;
	logic [AW-1:0] num;
	logic          load_res;

	assign cur_idx  = cur_q.channel[IW-1:0];
	assign acc_idx  = (state_q == adc_oa_pkg::BK_FRAME || state_q == adc_oa_pkg::BK_RESCALE)
		? idx_q : cur_idx;
	assign sum_sel  = sum_q[acc_idx];
	assign cnt_sel  = cnt_q[acc_idx];
	assign last_sel = last_q[acc_idx];

	assign smp          = cur_q.samples[idx_q];
	assign new_sum      = sum_sel + AW'(smp);
	assign new_cnt      = (cnt_sel == adc_oa_pkg::COUNT_MAX) ? cnt_sel : cnt_sel + AW'(1);
	assign need_rescale = new_sum >= adc_oa_pkg::RESCALE_LIMIT;
	assign last_idx     = (idx_q == LAST_CH);

	// a factor of zero behaves as one
	assign f_eff     = (cfg.factor == '0) ? FW'(1) : cfg.factor;
	assign f_one     = (f_eff == FW'(1));
	assign ch_ok     = ({1'b0, cur_q.channel} < adc_oa_pkg::CH_COUNT)
		&& (cur_q.channel < cfg.in_use);
	assign short_cnt = cnt_sel < AW'(f_eff);
	assign prod_ext  = AW'(prod_q);
	assign num       = (prod_ext > sum_sel) ? '0 : sum_sel - prod_ext;
	assign load_res  = (state_q == adc_oa_pkg::BK_OUT) && (!res_valid_q || !res_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			adc_oa_pkg::BK_IDLE: begin
				if (q_valid) begin
					unique case (q_head.op)
						adc_oa_pkg::OP_FRAME: state_d = adc_oa_pkg::BK_FRAME;
						adc_oa_pkg::OP_READ:  state_d = adc_oa_pkg::BK_RD_CHECK;
						adc_oa_pkg::OP_CLEAR: state_d = adc_oa_pkg::BK_CLEAR;
						default:              state_d = adc_oa_pkg::BK_IDLE;
					endcase
				end
			end
			adc_oa_pkg::BK_CLEAR: state_d = adc_oa_pkg::BK_IDLE;
			adc_oa_pkg::BK_FRAME: begin
				priority if (need_rescale) begin
					state_d = adc_oa_pkg::BK_RESCALE;
				end else if (last_idx) begin
					state_d = adc_oa_pkg::BK_IDLE;
				end
			end
			adc_oa_pkg::BK_RESCALE: begin
				if (div_rsp.done) begin
					state_d = last_idx ? adc_oa_pkg::BK_IDLE : adc_oa_pkg::BK_FRAME;
				end
			end
			adc_oa_pkg::BK_RD_CHECK: begin
				priority if (!ch_ok || short_cnt) begin
					state_d = adc_oa_pkg::BK_OUT;
				end else if (f_one) begin
					state_d = adc_oa_pkg::BK_RD_DIV2;
				end else begin
					state_d = adc_oa_pkg::BK_RD_DIV1;
				end
			end
			adc_oa_pkg::BK_RD_DIV1: begin
				if (div_rsp.done) begin
					state_d = adc_oa_pkg::BK_RD_MUL;
				end
			end
			adc_oa_pkg::BK_RD_MUL: state_d = adc_oa_pkg::BK_RD_SUB;
			adc_oa_pkg::BK_RD_SUB: state_d = adc_oa_pkg::BK_RD_DIV2;
			adc_oa_pkg::BK_RD_DIV2: begin
				if (div_rsp.done) begin
					state_d = adc_oa_pkg::BK_OUT;
				end
			end
			adc_oa_pkg::BK_OUT: begin
				if (load_res) begin
					state_d = adc_oa_pkg::BK_IDLE;
				end
			end
			default: state_d = adc_oa_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop              = (state_q == adc_oa_pkg::BK_IDLE) && q_valid;
		div_req.start    = 1'b0;
		div_req.dividend = sum_sel;
		div_req.divisor  = cnt_sel;
		unique case (state_q)
			adc_oa_pkg::BK_FRAME: begin
				div_req.start    = need_rescale;
				div_req.dividend = new_sum;
				div_req.divisor  = new_cnt;
			end
			adc_oa_pkg::BK_RD_CHECK: begin
				div_req.start = ch_ok && !short_cnt;
				if (!f_one) begin
					div_req.dividend = cnt_sel;
					div_req.divisor  = AW'(f_eff);
				end
			end
			adc_oa_pkg::BK_RD_SUB: begin
				div_req.start    = 1'b1;
				div_req.dividend = num;
				div_req.divisor  = q1_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= adc_oa_pkg::BK_IDLE;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < adc_oa_pkg::CHANNELS; i++) begin
				sum_q[i]  <= '0;
				cnt_q[i]  <= '0;
				last_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				adc_oa_pkg::BK_IDLE: begin
					idx_q <= '0;
				end
				adc_oa_pkg::BK_CLEAR: begin
					sum_q[cur_idx] <= '0;
					cnt_q[cur_idx] <= '0;
				end
				adc_oa_pkg::BK_FRAME: begin
					sum_q[idx_q]  <= new_sum;
					cnt_q[idx_q]  <= new_cnt;
					last_q[idx_q] <= smp;
					if (!need_rescale && !last_idx) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				adc_oa_pkg::BK_RESCALE: begin
					if (div_rsp.done) begin
						sum_q[idx_q] <= div_rsp.quotient;
						cnt_q[idx_q] <= AW'(1);
						if (!last_idx) begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		if (state_q == adc_oa_pkg::BK_RD_CHECK) begin
			val_q <= '0;
			rdy_q <= 1'b0;
		end
		if (state_q == adc_oa_pkg::BK_RD_DIV1 && div_rsp.done) begin
			q1_q  <= div_rsp.quotient;
			rem_q <= div_rsp.remainder[FW-1:0];
		end
		if (state_q == adc_oa_pkg::BK_RD_MUL) begin
			prod_q <= PW'(last_sel) * PW'(rem_q);
		end
		if (state_q == adc_oa_pkg::BK_RD_DIV2 && div_rsp.done) begin
			// saturate the reading
			val_q <= (div_rsp.quotient > AW'(adc_oa_pkg::READING_MAX))
				? adc_oa_pkg::READING_MAX : div_rsp.quotient[RW-1:0];
			rdy_q <= 1'b1;
		end
		if (load_res) begin
			res_q.reading   <= val_q;
			res_q.ready_res <= rdy_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// ===== design/adc_oversample_accumulator.sv =====
// Oversampling accumulator for a five-channel ADC.
// Request channel (req_valid / req_stall / req_item): a frame adds one
// sample per channel to the running sums, a read asks for one channel's
// reading, a clear zeroes one channel's sum and count. Unused request
// types are dropped on entry. Only reads produce a result.
// Result channel (res_valid / res_stall / res_item): one item per read.
// A two-entry request queue sits in front of a sequencer that owns the
// channel state and one shared radix-2 divider.
// Divisions per item in the sequencer:
//   frame: one for each channel whose sum hits the rescale point
//   clear: none
//   read : none when not ready, one for the plain average, two with
//          oversampling
// A held result stays in the output register while res_stall is high; the
// queue keeps taking requests until it fills, then raises req_stall.
// Reset clears all sums, counts and latest samples, empties the queue, and
// loads oversample_factor = 16 and channels_in_use = 5.
// Configuration writes (cfg_wen, cfg_idx, cfg_wdata) are taken on a clock edge with cfg_wen high.
module adc_oversample_accumulator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    req_valid,
	output logic                                    req_stall,
	input  adc_oa_pkg::req_item_t                   req_item,
	output logic                                    res_valid,
	input  logic                                    res_stall,
	output adc_oa_pkg::res_item_t                   res_item,
	input  logic                                    cfg_wen,
	input  logic [adc_oa_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [adc_oa_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	adc_oa_pkg::cfg_t     cfg_q;
	adc_oa_pkg::qent_t    q_head;
	logic                 q_valid;
	logic                 pop;
	adc_oa_pkg::div_req_t div_req;
	adc_oa_pkg::div_rsp_t div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.factor <= adc_oa_pkg::FACTOR_RESET;
			cfg_q.in_use <= adc_oa_pkg::IN_USE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				adc_oa_pkg::CFG_FACTOR: cfg_q.factor <= cfg_wdata[adc_oa_pkg::FACTOR_W-1:0];
				adc_oa_pkg::CFG_IN_USE: cfg_q.in_use <= cfg_wdata[adc_oa_pkg::IN_USE_W-1:0];
				default:                cfg_q        <= cfg_q;
			endcase
		end
	end

	adc_oa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_head    (q_head)
	);

	adc_oa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	adc_oa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

// ===== design/adc_oa_checker.sv =====
`include "adc_oversample_accumulator_defines.svh"

module adc_oa_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_stall,
	input adc_oa_pkg::req_item_t req_item,
	input logic                  res_valid,
	input logic                  res_stall,
	input adc_oa_pkg::res_item_t res_item
);

	// hold a stalled request
	`ADC_OA_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_item), "request changed while stalled")

	// hold a result that is not taken
	`ADC_OA_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item), "result changed while stalled")

	// a reading without ready is zero
	`ADC_OA_ASSERT_NOW(a_zero_not_ready, res_valid && !res_item.ready_res, res_item.reading == 16'd0, "nonzero reading without ready")

	// queue not full and no result right after reset
	`ADC_OA_ASSERT_NOW(a_empty_after_reset, !$past(arst_n), !req_stall && !res_valid, "not empty after reset")

endmodule

bind adc_oversample_accumulator adc_oa_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_item  (req_item),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

// ===== tb/adc_oversample_accumulator_tb.sv =====
`timescale 1ns / 100ps

module adc_oversample_accumulator_tb;

	localparam int unsigned CHANNELS   = adc_oa_pkg::CHANNELS;
	localparam int unsigned ACC_W      = adc_oa_pkg::ACC_W;
	localparam int unsigned CH_W       = adc_oa_pkg::CH_W;
	localparam int unsigned CFG_IDX_W  = adc_oa_pkg::CFG_IDX_W;
	localparam int unsigned CFG_DATA_W = adc_oa_pkg::CFG_DATA_W;
	localparam int unsigned FACTOR_W   = adc_oa_pkg::FACTOR_W;
	localparam int unsigned IN_USE_W   = adc_oa_pkg::IN_USE_W;
	localparam int unsigned READING_W  = adc_oa_pkg::READING_W;

	localparam logic [1:0] REQ_UNUSED    = 2'd3;
	localparam int         SETTLE_CYCLES = 250;
	localparam int         NUM_PHASES    = 8;
	localparam int         PHASE_ITEMS   = 130;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	adc_oa_pkg::req_item_t req_item  = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	adc_oa_pkg::res_item_t res_item;
	logic                  cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// predictor state
	logic [ACC_W-1:0]      chan_sum    [CHANNELS];
	logic [ACC_W-1:0]      chan_count  [CHANNELS];
	adc_oa_pkg::sample_t   chan_latest [CHANNELS];
	logic [FACTOR_W-1:0]   factor_setting;
	logic [IN_USE_W-1:0]   in_use_setting;
	adc_oa_pkg::res_item_t pending_readings [$];

	int fail_count    = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;

	adc_oversample_accumulator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic adc_oa_pkg::res_item_t predict_reading(input logic [CH_W-1:0] ch);
		adc_oa_pkg::res_item_t r;
		logic [ACC_W-1:0]      f;
		logic [ACC_W-1:0]      sum;
		logic [ACC_W-1:0]      cnt;
		logic [ACC_W-1:0]      sub;
		logic [ACC_W-1:0]      num;
		logic [ACC_W-1:0]      val;
		r = '0;
		if (ch >= in_use_setting || ch >= CHANNELS)
			return r;
		f = (factor_setting == '0) ? 32'd1 : ACC_W'(factor_setting);
		sum = chan_sum[ch];
		cnt = chan_count[ch];
		if (cnt < f)
			return r;
		r.ready_res = 1'b1;
		if (f <= 1) begin
			val = sum / cnt;
		end else begin
			sub = ACC_W'(chan_latest[ch]) * (cnt % f);
			num = (sub > sum) ? '0 : sum - sub;
			val = num / (cnt / f);
		end
		r.reading = (val > 32'd65535) ? adc_oa_pkg::READING_MAX : val[READING_W-1:0];
		return r;
	endfunction

	function automatic void absorb_frame(input adc_oa_pkg::req_item_t it);
		adc_oa_pkg::sample_t s [CHANNELS];
		s[0] = it.sample_0;
		s[1] = it.sample_1;
		s[2] = it.sample_2;
		s[3] = it.sample_3;
		s[4] = it.sample_4;
		for (int i = 0; i < CHANNELS; i++) begin
			chan_sum[i] = chan_sum[i] + ACC_W'(s[i]);
			if (chan_count[i] != adc_oa_pkg::COUNT_MAX)
				chan_count[i] = chan_count[i] + 1;
			chan_latest[i] = s[i];
			// rescale to the average once the sum nears the top
			if (chan_sum[i] >= adc_oa_pkg::RESCALE_LIMIT) begin
				chan_sum[i] = chan_sum[i] / chan_count[i];
				chan_count[i] = 1;
			end
		end
	endfunction

	function automatic void model_step(input adc_oa_pkg::req_item_t it);
		case (it.req_type)
			adc_oa_pkg::REQ_FRAME: begin
				absorb_frame(it);
			end
			adc_oa_pkg::REQ_READ: begin
				pending_readings.push_back(predict_reading(it.channel));
			end
			adc_oa_pkg::REQ_CLEAR: begin
				if (it.channel < CHANNELS) begin
					chan_sum[it.channel] = '0;
					chan_count[it.channel] = '0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic adc_oa_pkg::req_item_t control_request(input logic [1:0] kind,
			input logic [CH_W-1:0] ch);
		adc_oa_pkg::req_item_t it;
		it = '0;
		it.req_type = kind;
		it.channel = ch;
		return it;
	endfunction

	function automatic adc_oa_pkg::sample_t random_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return adc_oa_pkg::sample_t'($urandom);
		endcase
	endfunction

	task automatic push_request(input adc_oa_pkg::req_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		model_step(it);
	endtask

	// hold the sender until every reading is back and the sequencer has gone quiet
	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		drain_results();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (idx == adc_oa_pkg::CFG_FACTOR)
			factor_setting = val[FACTOR_W-1:0];
		else
			in_use_setting = val[IN_USE_W-1:0];
	endtask

	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		adc_oa_pkg::res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected reading %0d ready_res %0b", res_item.reading,
					res_item.ready_res);
				fail_count++;
			end else begin
				want = pending_readings.pop_front();
				if (res_item.reading !== want.reading) begin
					$error("reading: expected %0d, got %0d", want.reading,
						res_item.reading);
					fail_count++;
				end
				if (res_item.ready_res !== want.ready_res) begin
					$error("ready_res: expected %0b, got %0b", want.ready_res,
						res_item.ready_res);
					fail_count++;
				end
			end
		end
	end

	// all counts are zero after reset: no channel is ready
	task automatic test_empty_channels();
		for (int c = 0; c < CHANNELS; c++)
			push_request(control_request(adc_oa_pkg::REQ_READ, CH_W'(c)));
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd5));
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd7));
		push_request(control_request(REQ_UNUSED, 3'd0));
		push_request(control_request(adc_oa_pkg::REQ_CLEAR, 3'd7));
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd0));
	endtask

	// channel zero saturates, channel one hits the clamp on the correction term
	task automatic test_saturation_and_clamp();
		adc_oa_pkg::req_item_t it;
		write_setting(adc_oa_pkg::CFG_FACTOR, 9'd17);
		for (int i = 0; i < 19; i++) begin
			it = '0;
			it.req_type = adc_oa_pkg::REQ_FRAME;
			it.channel = CH_W'(i);
			it.sample_0 = 12'hFFF;
			it.sample_1 = (i == 18) ? 12'hFFF : 12'h000;
			it.sample_2 = i[0] ? 12'h555 : 12'hAAA;
			it.sample_3 = 12'(i * 200);
			it.sample_4 = 12'(4095 - i);
			push_request(it);
		end
		for (int c = 0; c < CHANNELS; c++)
			push_request(control_request(adc_oa_pkg::REQ_READ, CH_W'(c)));
		write_setting(adc_oa_pkg::CFG_FACTOR, 9'd1);
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd4));
		write_setting(adc_oa_pkg::CFG_FACTOR, 9'd0);
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd3));
	endtask

	task automatic test_clear_and_range();
		push_request(control_request(adc_oa_pkg::REQ_CLEAR, 3'd2));
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd2));
		push_request(control_request(adc_oa_pkg::REQ_CLEAR, 3'd6));
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd6));
		write_setting(adc_oa_pkg::CFG_IN_USE, 9'd0);
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd0));
		write_setting(adc_oa_pkg::CFG_IN_USE, 9'd3);
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd3));
		push_request(control_request(adc_oa_pkg::REQ_READ, 3'd0));
	endtask

	task automatic test_random_traffic();
		adc_oa_pkg::req_item_t it;
		int                    sent;
		int                    pick;
		int                    clear_pct;
		int                    factor;
		int                    in_use;
		bit                    paused;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin factor = 16;  in_use = 5; clear_pct = 3; end
				1: begin factor = 1;   in_use = 5; clear_pct = 3; end
				2: begin factor = 0;   in_use = 3; clear_pct = 3; end
				3: begin factor = 2;   in_use = 5; clear_pct = 2; end
				4: begin factor = $urandom_range(3, 40); in_use = 1; clear_pct = 2; end
				5: begin factor = 256; in_use = 5; clear_pct = 0; end
				6: begin factor = 255; in_use = 4; clear_pct = 0; end
				default: begin factor = 256; in_use = 5; clear_pct = 0; end
			endcase
			write_setting(adc_oa_pkg::CFG_FACTOR, CFG_DATA_W'(factor));
			write_setting(adc_oa_pkg::CFG_IN_USE, CFG_DATA_W'(in_use));
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 79; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 79; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				if (sent == PHASE_ITEMS / 2 && !paused) begin
					drain_results();
					paused = 1'b1;
				end
				it.channel = ($urandom_range(9) == 0) ? CH_W'($urandom_range(7, 5))
					: CH_W'($urandom_range(4));
				it.sample_0 = random_sample();
				it.sample_1 = random_sample();
				it.sample_2 = random_sample();
				it.sample_3 = random_sample();
				it.sample_4 = random_sample();
				pick = $urandom_range(99);
				if (pick < 2)
					it.req_type = REQ_UNUSED;
				else if (pick < 2 + clear_pct)
					it.req_type = adc_oa_pkg::REQ_CLEAR;
				else if (pick < 45)
					it.req_type = adc_oa_pkg::REQ_READ;
				else
					it.req_type = adc_oa_pkg::REQ_FRAME;
				push_request(it);
				if (it.req_type != REQ_UNUSED)
					sent++;
			end
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		factor_setting = adc_oa_pkg::FACTOR_RESET;
		in_use_setting = adc_oa_pkg::IN_USE_RESET;
		for (int i = 0; i < CHANNELS; i++) begin
			chan_sum[i] = '0;
			chan_count[i] = '0;
			chan_latest[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_channels();
		test_saturation_and_clamp();
		test_clear_and_range();
		test_random_traffic();
		drain_results();
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/adc_oa_pkg.sv
design/adc_oa_div.sv
design/adc_oa_front.sv
design/adc_oa_back.sv
design/adc_oversample_accumulator.sv
design/adc_oa_checker.sv
tb/adc_oversample_accumulator_tb.sv
